// ===== sv/utfd_pkg.sv =====
// Shared types and constants for the UTF-8 decoder.
`timescale 1ns / 1ps

package utfd_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

    // Byte classes
    localparam logic [7:0] BYTE_C0      = 8'hC0;
    localparam logic [7:0] BYTE_C1      = 8'hC1;
    localparam logic [7:0] BYTE_F5      = 8'hF5;
    localparam logic [7:0] MASK_HI1     = 8'h80;
    localparam logic [7:0] MASK_HI2     = 8'hC0;
    localparam logic [7:0] MASK_HI3     = 8'hE0;
    localparam logic [7:0] MASK_HI4     = 8'hF0;
    localparam logic [7:0] LEAD_2B      = 8'hC0;
    localparam logic [7:0] LEAD_3B      = 8'hE0;
    localparam logic [7:0] PAY_2B       = 8'h1F;
    localparam logic [7:0] PAY_3B       = 8'h0F;
    localparam logic [7:0] PAY_4B       = 8'h07;
    localparam logic [7:0] PAY_CONT     = 8'h3F;

    // Continuation counts left after a lead byte
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    // One queue entry: the results caused by one input byte
    typedef struct packed {
        logic            two;
        logic [CP_W-1:0] cp0;
        logic [CP_W-1:0] cp1;
    } t_entry;

endpackage

// ===== sv/utfd_front.sv =====
// Front end: accepts bytes, tracks the pending sequence, builds result entries.
`timescale 1ns / 1ps

module utfd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_byte_value,
    input  logic                      i_is_last_byte,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output utfd_pkg::t_entry          o_q_entry
);

    logic [utfd_pkg::CP_W-1:0] r_partial;
    logic [utfd_pkg::CP_W-1:0] n_partial;
    logic [1:0]                r_pending;
    logic [1:0]                n_pending;
    logic                      accept;
    logic                      is_invalid;
    logic                      is_ascii;
    logic                      is_lead;
    logic [1:0]                cnt;
    logic [utfd_pkg::CP_W-1:0] e0;
    logic [utfd_pkg::CP_W-1:0] e1;
    logic [utfd_pkg::CP_W-1:0] shifted;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // Byte classification
    assign is_invalid = (i_byte_value == utfd_pkg::BYTE_C0) ||
                        (i_byte_value == utfd_pkg::BYTE_C1) ||
                        (i_byte_value >= utfd_pkg::BYTE_F5);
    assign is_ascii   = (i_byte_value & utfd_pkg::MASK_HI1) == 8'h00;
    assign is_lead    = (i_byte_value & utfd_pkg::MASK_HI2) == utfd_pkg::MASK_HI2;
    assign shifted    = {r_partial[utfd_pkg::CP_W-7:0],
                         i_byte_value[5:0] & utfd_pkg::PAY_CONT[5:0]};

    // Decode: next state and up to two results
    always_comb begin
        n_partial = r_partial;
        n_pending = r_pending;
        cnt       = 2'd0;
        e0        = utfd_pkg::CP_REPLACEMENT;
        e1        = utfd_pkg::CP_REPLACEMENT;
        priority if (is_invalid) begin
            cnt       = 2'd1;
            n_pending = utfd_pkg::PEND_NONE;
        end else if (is_ascii) begin
            if (r_pending != utfd_pkg::PEND_NONE) begin
                cnt = 2'd2;
                e1  = {13'd0, i_byte_value};
            end else begin
                cnt = 2'd1;
                e0  = {13'd0, i_byte_value};
            end
            n_pending = utfd_pkg::PEND_NONE;
        end else if (is_lead) begin
            if (r_pending != utfd_pkg::PEND_NONE) begin
                cnt = 2'd1;
            end
            priority if ((i_byte_value & utfd_pkg::MASK_HI3) == utfd_pkg::LEAD_2B) begin
                n_partial = {13'd0, i_byte_value & utfd_pkg::PAY_2B};
                n_pending = utfd_pkg::PEND_ONE;
            end else if ((i_byte_value & utfd_pkg::MASK_HI4) == utfd_pkg::LEAD_3B) begin
                n_partial = {13'd0, i_byte_value & utfd_pkg::PAY_3B};
                n_pending = utfd_pkg::PEND_TWO;
            end else begin
                n_partial = {13'd0, i_byte_value & utfd_pkg::PAY_4B};
                n_pending = utfd_pkg::PEND_THREE;
            end
        end else begin
            if (r_pending == utfd_pkg::PEND_NONE) begin
                cnt = 2'd1;
            end else begin
                n_partial = shifted;
                n_pending = r_pending - 2'd1;
                if (r_pending == utfd_pkg::PEND_ONE) begin
                    cnt = 2'd1;
                    e0  = shifted;
                end
            end
        end

        // End of string flushes an unfinished sequence
        if (i_is_last_byte && (n_pending != utfd_pkg::PEND_NONE)) begin
            if (cnt == 2'd0) begin
                cnt = 2'd1;
                e0  = utfd_pkg::CP_REPLACEMENT;
            end else if (cnt == 2'd1) begin
                cnt = 2'd2;
                e1  = utfd_pkg::CP_REPLACEMENT;
            end
            n_pending = utfd_pkg::PEND_NONE;
            n_partial = '0;
        end
    end

    assign o_q_push      = accept && (cnt != 2'd0);
    assign o_q_entry.two = (cnt == 2'd2);
    assign o_q_entry.cp0 = e0;
    assign o_q_entry.cp1 = e1;

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= utfd_pkg::PEND_NONE;
        end else if (accept) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
        end
    end

endmodule

// ===== sv/utfd_queue.sv =====
// Short FIFO of result entries between the front and back ends.
`timescale 1ns / 1ps

module utfd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utfd_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output utfd_pkg::t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    utfd_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/utfd_back.sv =====
// Back end: unpacks queue entries into one output beat per cycle while the output is not stalled.
`timescale 1ns / 1ps

module utfd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  utfd_pkg::t_entry          i_q_entry,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [utfd_pkg::CP_W-1:0] o_code_point,
    output logic                      o_last_of_item
);

    utfd_pkg::t_entry r_entry;
    logic             r_valid;
    logic             r_phase;
    logic             beat_done;
    logic             need_load;

    assign beat_done = r_valid && !i_out_stall;
    // Register is free when empty or when its final beat goes out now
    assign need_load = !r_valid || (beat_done && (!r_entry.two || r_phase));
    assign o_q_pop   = need_load && !i_q_empty;

    assign o_out_valid    = r_valid;
    assign o_code_point   = r_phase ? r_entry.cp1 : r_entry.cp0;
    assign o_last_of_item = !r_entry.two || r_phase;

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_entry <= i_q_entry;
        end
    end

    // Output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (need_load) begin
            r_valid <= !i_q_empty;
            r_phase <= 1'b0;
        end else if (beat_done) begin
            r_phase <= 1'b1;
        end
    end

endmodule

// ===== sv/utf8_to_codepoint_decoder.sv =====
// A byte's first code point is registered in the entry queue and then in the output register.
// Throughput: one byte per cycle in unless the queue is full; one code point per cycle out
// unless stalled. A byte giving two code points holds the output for both of its beats;
// a run of them fills the queue. Reset (synchronous, active low) clears the pending sequence,
// the queue and the output valid. Top level: decoder front end, entry queue, output back end.
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_byte_value,
    input  logic                      i_is_last_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [20:0]               o_code_point,
    output logic                      o_last_of_item
);

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    utfd_pkg::t_entry q_wr_entry;
    utfd_pkg::t_entry q_rd_entry;

    utfd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_value   (i_byte_value),
        .i_is_last_byte (i_is_last_byte),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_entry      (q_wr_entry)
    );

    utfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (q_rd_entry)
    );

    utfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_entry      (q_rd_entry),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_code_point   (o_code_point),
        .o_last_of_item (o_last_of_item)
    );

endmodule
